[design/mcf_pkg.sv]
// Package for the motor current command framer.
// Holds frame constants, byte positions and the bytewise CRC-16 update.
// No dependencies.
package mcf_pkg;

  // Frame framing bytes and command codes
  localparam logic [7:0] FRAME_START = 8'h02;
  localparam logic [7:0] FRAME_END   = 8'h03;
  localparam logic [7:0] PAYLOAD_LEN = 8'h05;
  localparam logic [7:0] CODE_DRIVE  = 8'h06;
  localparam logic [7:0] CODE_BRAKE  = 8'h07;

  // CRC-16 polynomial, zero initial value, MSB first
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'h0000;

  // Operation codes on the op input
  localparam logic OP_DRIVE = 1'b0;
  localparam logic OP_BRAKE = 1'b1;

  // Byte positions within the frame
  typedef logic [3:0] byte_idx_t;
  localparam byte_idx_t IDX_START  = 4'd0;
  localparam byte_idx_t IDX_LEN    = 4'd1;
  localparam byte_idx_t IDX_CODE   = 4'd2;
  localparam byte_idx_t IDX_CUR3   = 4'd3;
  localparam byte_idx_t IDX_CUR2   = 4'd4;
  localparam byte_idx_t IDX_CUR1   = 4'd5;
  localparam byte_idx_t IDX_CUR0   = 4'd6;
  localparam byte_idx_t IDX_CRC_HI = 4'd7;
  localparam byte_idx_t IDX_CRC_LO = 4'd8;
  localparam byte_idx_t IDX_END    = 4'd9;

  // Fold one byte into the CRC, eight bit steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] acc;
    acc = crc_in ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (acc[15]) begin
        acc = {acc[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        acc = {acc[14:0], 1'b0};
      end
    end
    return acc;
  endfunction

endpackage

[design/motor_current_command_framer_top.sv]
// Motor current command framer: one command in, a ten-byte frame out.
// A command transfer arms the serialiser at the start position; the start byte then enters the output register.
// Throughput: one byte per cycle while the output register is free or draining, set by
// the single byte serialiser; the next command is taken as the end byte enters the output register.
// The CRC is folded one payload byte per cycle as the bytes are emitted.
// Reset (rst, synchronous) empties the serialiser and the output register.
module motor_current_command_framer_top
  import mcf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               op,
  input  logic signed [31:0] current_req,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         frame_byte,
  output logic               last
);

  // Serialiser state
  logic        gen_active;
  byte_idx_t   idx;
  logic        cmd_op;
  logic [31:0] cmd_word;
  logic [15:0] crc;

  logic        produce;
  logic        load;
  logic [7:0]  byte_next;
  logic [15:0] crc_next;

  // Handshake: produce when the output register is free or draining
  assign produce  = gen_active && (!out_valid || out_ready);
  assign in_ready = !gen_active || (produce && (idx == IDX_END));
  assign load     = in_valid && in_ready;

  // Byte select for the current frame position
  always_comb begin
    case (idx)
      IDX_START:  byte_next = FRAME_START;
      IDX_LEN:    byte_next = PAYLOAD_LEN;
      IDX_CODE:   byte_next = (cmd_op == OP_BRAKE) ? CODE_BRAKE : CODE_DRIVE;
      IDX_CUR3:   byte_next = cmd_word[31:24];
      IDX_CUR2:   byte_next = cmd_word[23:16];
      IDX_CUR1:   byte_next = cmd_word[15:8];
      IDX_CUR0:   byte_next = cmd_word[7:0];
      IDX_CRC_HI: byte_next = crc[15:8];
      IDX_CRC_LO: byte_next = crc[7:0];
      IDX_END:    byte_next = FRAME_END;
      default:    byte_next = 8'h00;
    endcase
  end

  // CRC covers the code byte and the four current bytes
  always_comb begin
    crc_next = crc;
    if (produce && (idx >= IDX_CODE) && (idx <= IDX_CUR0)) begin
      crc_next = crc_byte(crc, byte_next);
    end
  end

  // Serialiser control
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_active <= 1'b0;
      idx        <= IDX_START;
    end else if (load) begin
      gen_active <= 1'b1;
      idx        <= IDX_START;
    end else if (produce) begin
      if (idx == IDX_END) begin
        gen_active <= 1'b0;
        idx        <= IDX_START;
      end else begin
        idx <= byte_idx_t'(idx + 4'd1);
      end
    end
  end

  // Command and CRC payload registers
  always_ff @(posedge clk) begin
    if (load) begin
      cmd_op   <= op;
      cmd_word <= current_req;
      crc      <= CRC_INIT;
    end else begin
      crc <= crc_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (produce) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      frame_byte <= byte_next;
      last       <= (idx == IDX_END);
    end
  end

  // Checks
  a_last_is_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> frame_byte == FRAME_END)
    else $error("last marker on a byte other than the end byte");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    gen_active |-> idx <= IDX_END)
    else $error("frame position out of range");

  a_start_follows_end: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && $past(out_valid && out_ready && last) && out_valid
      |-> frame_byte == FRAME_START && !last)
    else $error("frame after an end byte does not open with the start byte");

  a_load_restarts: assert property (@(posedge clk) disable iff (rst)
    load |=> gen_active && idx == IDX_START && crc == CRC_INIT)
    else $error("command transfer did not restart the serialiser");

endmodule
